@@ rtl/core/tfn_pkg.sv @@
// Shared widths and stage counts for the triangle face normal pipeline.
`default_nettype none
package tfn_pkg;

   localparam int COORD_W    = 16;
   localparam int OUT_W      = 16;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int CROSS_W    = PROD_W + 1;
   localparam int MAG_W      = CROSS_W - 1;
   localparam int LO_W       = (MAG_W + 1) / 2;
   localparam int HI_W       = MAG_W - LO_W;
   localparam int SQ_W       = 2 * MAG_W;
   localparam int SUM_W      = SQ_W + 2;
   localparam int FRAC_SHIFT = 28;
   localparam int TGT_W      = SQ_W + FRAC_SHIFT;
   localparam int KBITS      = 15;
   localparam int REM_W      = SUM_W + 2 * KBITS + 1;
   localparam int ACC_W      = SUM_W + KBITS;
   localparam int FRONT      = 7;
   localparam int NSTAGE     = FRONT + KBITS + 1;

   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [CROSS_W-1:0] cross_type;

endpackage
`default_nettype wire

@@ rtl/core/tfn_norm_lane.sv @@
// Bit-serial square root division pipeline for one normal component.
`default_nettype none
module tfn_norm_lane
   import tfn_pkg::*;
(
   input  wire logic             clock,
   input  wire logic [KBITS-1:0] stage_en,
   input  wire logic [SUM_W-1:0] len_sq,
   input  wire logic [TGT_W-1:0] target,
   input  wire logic             neg_in,
   output logic      [KBITS-1:0] mag_out,
   output logic                  neg_out
);

   logic [REM_W-1:0] rem_ff   [KBITS];
   logic [ACC_W-1:0] acc_ff   [KBITS];
   logic [SUM_W-1:0] len_ff   [KBITS];
   logic [KBITS-1:0] k_ff     [KBITS];
   logic             neg_ff   [KBITS];

   logic [REM_W-1:0] rem_prev [KBITS];
   logic [ACC_W-1:0] acc_prev [KBITS];
   logic [SUM_W-1:0] len_prev [KBITS];
   logic [KBITS-1:0] k_prev   [KBITS];
   logic             neg_prev [KBITS];
   logic [REM_W-1:0] need     [KBITS];
   logic             fits     [KBITS];
   logic [REM_W-1:0] rem_in   [KBITS];
   logic [ACC_W-1:0] acc_in   [KBITS];
   logic [KBITS-1:0] k_in     [KBITS];

   // keep rem = target - k^2*S and acc = k*S; try one bit of k per stage
   always_comb begin
      for (int j = 0; j < KBITS; j++) begin
         if (j == 0) begin
            rem_prev[j] = REM_W'(target);
            acc_prev[j] = '0;
            len_prev[j] = len_sq;
            k_prev[j]   = '0;
            neg_prev[j] = neg_in;
         end else begin
            rem_prev[j] = rem_ff[j-1];
            acc_prev[j] = acc_ff[j-1];
            len_prev[j] = len_ff[j-1];
            k_prev[j]   = k_ff[j-1];
            neg_prev[j] = neg_ff[j-1];
         end
         need[j] = (REM_W'(acc_prev[j]) << (KBITS - j))
                 + (REM_W'(len_prev[j]) << (2 * (KBITS - 1 - j)));
         fits[j] = need[j] <= rem_prev[j];
         rem_in[j] = fits[j] ? rem_prev[j] - need[j] : rem_prev[j];
         acc_in[j] = fits[j] ? acc_prev[j] + (ACC_W'(len_prev[j]) << (KBITS - 1 - j))
                             : acc_prev[j];
         k_in[j]   = fits[j] ? k_prev[j] | (KBITS'(1) << (KBITS - 1 - j)) : k_prev[j];
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < KBITS; j++) begin
         if (stage_en[j]) begin
            rem_ff[j] <= rem_in[j];
            acc_ff[j] <= acc_in[j];
            len_ff[j] <= len_prev[j];
            k_ff[j]   <= k_in[j];
            neg_ff[j] <= neg_prev[j];
         end
      end
   end

   assign mag_out = k_ff[KBITS-1];
   assign neg_out = neg_ff[KBITS-1];

endmodule
`default_nettype wire

@@ rtl/core/triangle_face_normal_unit.sv @@
// Top level of the triangle face normal pipeline.
// Throughput: one triangle per cycle unless the output stalls; 7 front stages
// (differences, cross product, squares, length) feed 15 stages of bit-serial
// normalization. A stalled output holds stages upstream only as far as they
// are full. Reset clears the stage valid bits; data registers are not reset.
`default_nettype none
module triangle_face_normal_unit
   import tfn_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic signed [COORD_W-1:0] req_first_x,
   input  wire logic signed [COORD_W-1:0] req_first_y,
   input  wire logic signed [COORD_W-1:0] req_first_z,
   input  wire logic signed [COORD_W-1:0] req_second_x,
   input  wire logic signed [COORD_W-1:0] req_second_y,
   input  wire logic signed [COORD_W-1:0] req_second_z,
   input  wire logic signed [COORD_W-1:0] req_third_x,
   input  wire logic signed [COORD_W-1:0] req_third_y,
   input  wire logic signed [COORD_W-1:0] req_third_z,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [OUT_W-1:0]        rsp_normal_x,
   output logic signed [OUT_W-1:0]        rsp_normal_y,
   output logic signed [OUT_W-1:0]        rsp_normal_z,
   output logic                           rsp_degenerate
);

   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] valid_in;
   logic [NSTAGE:0]   adv;

   diff_type          q_ff     [3];
   diff_type          p_ff     [3];
   prod_type          pa_ff    [3];
   prod_type          pb_ff    [3];
   prod_type          pa_in    [3];
   prod_type          pb_in    [3];
   cross_type         cross_ff [3];
   cross_type         cross_in [3];
   logic [MAG_W-1:0]  mag_ff   [3];
   logic              neg3_ff  [3];
   logic [2*HI_W-1:0] hh_ff    [3];
   logic [HI_W+LO_W-1:0] hl_ff [3];
   logic [2*LO_W-1:0] ll_ff    [3];
   logic              neg4_ff  [3];
   logic [SQ_W-1:0]   sq_ff    [3];
   logic              neg5_ff  [3];
   logic [SUM_W-1:0]  sum_ff;
   logic [TGT_W-1:0]  tgt_ff   [3];
   logic              neg6_ff  [3];
   logic              deg6_ff;
   logic [KBITS-1:0]  deg_line_ff;
   logic [KBITS-1:0]  deg_line_in;
   logic [KBITS-1:0]  lane_mag [3];
   logic              lane_neg [3];
   logic [OUT_W-1:0]  norm_in  [3];
   logic [OUT_W-1:0]  norm_ff  [3];
   logic              deg_out_ff;

   // stage handshake: a stage advances when empty or when its successor moves
   always_comb begin
      adv[NSTAGE] = rsp_ready;
      for (int i = NSTAGE - 1; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   assign valid_in  = {valid_ff[NSTAGE-2:0], req_valid};
   assign req_ready = adv[0];
   assign rsp_valid = valid_ff[NSTAGE-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NSTAGE; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   // stage 0: edge vectors
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         q_ff[0] <= diff_type'(req_second_x) - diff_type'(req_first_x);
         q_ff[1] <= diff_type'(req_second_y) - diff_type'(req_first_y);
         q_ff[2] <= diff_type'(req_second_z) - diff_type'(req_first_z);
         p_ff[0] <= diff_type'(req_third_x) - diff_type'(req_first_x);
         p_ff[1] <= diff_type'(req_third_y) - diff_type'(req_first_y);
         p_ff[2] <= diff_type'(req_third_z) - diff_type'(req_first_z);
      end
   end

   // stages 1 and 2: cross product terms and their differences
   always_comb begin
      pa_in[0] = p_ff[1] * q_ff[2];
      pb_in[0] = p_ff[2] * q_ff[1];
      pa_in[1] = p_ff[2] * q_ff[0];
      pb_in[1] = p_ff[0] * q_ff[2];
      pa_in[2] = p_ff[0] * q_ff[1];
      pb_in[2] = p_ff[1] * q_ff[0];
      for (int i = 0; i < 3; i++) begin
         cross_in[i] = cross_type'(pa_ff[i]) - cross_type'(pb_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (adv[1]) begin
            pa_ff[i] <= pa_in[i];
            pb_ff[i] <= pb_in[i];
         end
         if (adv[2]) begin
            cross_ff[i] <= cross_in[i];
         end
         if (adv[3]) begin
            mag_ff[i]  <= cross_ff[i][CROSS_W-1] ? MAG_W'(-cross_ff[i])
                                                 : MAG_W'(cross_ff[i]);
            neg3_ff[i] <= cross_ff[i][CROSS_W-1];
         end
         if (adv[4]) begin
            hh_ff[i]   <= mag_ff[i][MAG_W-1:LO_W] * mag_ff[i][MAG_W-1:LO_W];
            hl_ff[i]   <= mag_ff[i][MAG_W-1:LO_W] * mag_ff[i][LO_W-1:0];
            ll_ff[i]   <= mag_ff[i][LO_W-1:0] * mag_ff[i][LO_W-1:0];
            neg4_ff[i] <= neg3_ff[i];
         end
         if (adv[5]) begin
            sq_ff[i]   <= (SQ_W'(hh_ff[i]) << (2 * LO_W))
                        + (SQ_W'(hl_ff[i]) << (LO_W + 1))
                        + SQ_W'(ll_ff[i]);
            neg5_ff[i] <= neg4_ff[i];
         end
         if (adv[6]) begin
            tgt_ff[i]  <= {sq_ff[i], FRAC_SHIFT'(0)};
            neg6_ff[i] <= neg5_ff[i];
         end
      end
      if (adv[6]) begin
         sum_ff  <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
         deg6_ff <= (sq_ff[0] == '0) && (sq_ff[1] == '0) && (sq_ff[2] == '0);
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_lane
      tfn_norm_lane u_lane (
         .clock    (clock),
         .stage_en (adv[FRONT+KBITS-1:FRONT]),
         .len_sq   (sum_ff),
         .target   (tgt_ff[g]),
         .neg_in   (neg6_ff[g]),
         .mag_out  (lane_mag[g]),
         .neg_out  (lane_neg[g])
      );
   end

   assign deg_line_in = {deg_line_ff[KBITS-2:0], deg6_ff};

   always_ff @(posedge clock) begin
      for (int j = 0; j < KBITS; j++) begin
         if (adv[FRONT+j]) begin
            deg_line_ff[j] <= deg_line_in[j];
         end
      end
   end

   // output stage: apply sign, force zero on a degenerate triangle
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (deg_line_ff[KBITS-1]) begin
            norm_in[i] = '0;
         end else if (lane_neg[i]) begin
            norm_in[i] = ~OUT_W'(lane_mag[i]) + OUT_W'(1);
         end else begin
            norm_in[i] = OUT_W'(lane_mag[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[NSTAGE-1]) begin
         for (int i = 0; i < 3; i++) begin
            norm_ff[i] <= norm_in[i];
         end
         deg_out_ff <= deg_line_ff[KBITS-1];
      end
   end

   assign rsp_normal_x   = norm_ff[0];
   assign rsp_normal_y   = norm_ff[1];
   assign rsp_normal_z   = norm_ff[2];
   assign rsp_degenerate = deg_out_ff;

`ifndef SYNTHESIS
   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0)
      else $error("degenerate result with nonzero normal");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |->
         rsp_normal_x <= 16'sd16384 && rsp_normal_x >= -16'sd16384 &&
         rsp_normal_y <= 16'sd16384 && rsp_normal_y >= -16'sd16384 &&
         rsp_normal_z <= 16'sd16384 && rsp_normal_z >= -16'sd16384)
      else $error("normal component beyond unit scale");

   a_entry_tracked: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff[0])
      else $error("transfer lost at pipeline entry");
`endif

endmodule
`default_nettype wire
